/* src/assert_macros.svh */
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Expression must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition seen");

`endif

/* src/lcdw_pkg.sv */
package lcdw_pkg;

  localparam int NUMBER_BITS_DEF = 32;
  localparam int NUM_MAX_BITS    = 32;
  localparam int BCD_DIGITS      = 10;
  localparam int BCD_W           = BCD_DIGITS * 4;
  localparam int FIFO_DEPTH_DEF  = 4;

  // request codes
  localparam logic [1:0] CMD_CHAR   = 2'd0;
  localparam logic [1:0] CMD_INSTR  = 2'd1;
  localparam logic [1:0] CMD_NUMBER = 2'd2;
  localparam logic [1:0] CMD_GOTO   = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_LOC = 2'd1;
  localparam logic [1:0] ST_SAT = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_FOUR_BIT    = 2'd0;
  localparam logic [1:0] REG_MAX_LINES   = 2'd1;
  localparam logic [1:0] REG_MAX_COLUMNS = 2'd2;

  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;

  // one byte-level request from the front to the back
  typedef struct packed {
    logic       rs;
    logic [7:0] data;
    logic       valid;
    logic       last;
    logic [1:0] status;
  } lcdw_req_t;

  function automatic logic [7:0] line_base(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = 8'h80;
      2'd1:    b = 8'hC0;
      2'd2:    b = 8'h94;
      default: b = 8'hD4;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] c;
    if (d < 4'd10) c = 8'h30 + {4'd0, d};
    else           c = 8'h41 + {4'd0, d} - 8'd10;
    return c;
  endfunction

endpackage

/* src/char_lcd_format_and_bus_writer_unit.sv */
// Character LCD writer. Each request (character, command byte, number or
// goto) becomes a run of LCD bus transfers, one result per transfer, with
// last set on the final one; in 4-bit mode every byte goes out as two
// results, upper nibble first, in bus_value[7:4]. A front end takes one
// request at a time and keeps full high until it has queued every byte of
// it, waiting whenever the byte queue is full; a decimal number is first
// converted from binary to BCD, one of its NUMBER_BITS bits per cycle,
// while a hex number needs no conversion. A four-entry byte queue lets
// the back end drain independently; it delivers at most one result per
// cycle into an output register and holds each result until it is popped,
// so a request yields between one and twelve results. A goto outside the
// configured lines or columns yields a single result with write_valid low
// and status 1. Write the configuration registers only while idle.
module char_lcd_format_and_bus_writer_unit
  import lcdw_pkg::*;
#(
  parameter int NUMBER_BITS = NUMBER_BITS_DEF,
  parameter int FIFO_DEPTH  = FIFO_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // request side
  input  logic               push,
  output logic               full,
  input  logic [1:0]         cmd,
  input  logic [7:0]         byte_value,
  input  logic signed [31:0] number,
  input  logic               signed_mode,
  input  logic [3:0]         number_format,
  input  logic [2:0]         line,
  input  logic [5:0]         column,
  // result side
  output logic               empty,
  input  logic               pop,
  output logic               register_select,
  output logic [7:0]         bus_value,
  output logic               write_valid,
  output logic               last,
  output logic [1:0]         status,
  // configuration
  input  logic               cfg_wr,
  input  logic [1:0]         cfg_addr,
  input  logic [5:0]         cfg_wdata
);

  logic       four_bit_mode;
  logic [2:0] max_lines;
  logic [5:0] max_columns;

  logic       q_push;
  lcdw_req_t  q_data;
  logic       q_full;
  logic       q_pop;
  lcdw_req_t  q_head;
  logic       q_empty;

  // configuration registers; writes to unused indexes drop
  always_ff @(posedge clk) begin
    if (rst) begin
      four_bit_mode <= 1'b1;
      max_lines     <= 3'd4;
      max_columns   <= 6'd20;
    end else if (cfg_wr) begin
      case (cfg_addr)
        REG_FOUR_BIT:    four_bit_mode <= cfg_wdata[0];
        REG_MAX_LINES:   max_lines     <= cfg_wdata[2:0];
        REG_MAX_COLUMNS: max_columns   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // classify the request and produce the byte sequence
  lcdw_front #(
    .NUMBER_BITS (NUMBER_BITS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .cmd           (cmd),
    .byte_value    (byte_value),
    .number        (number),
    .signed_mode   (signed_mode),
    .number_format (number_format),
    .line          (line),
    .column        (column),
    .max_lines     (max_lines),
    .max_columns   (max_columns),
    .q_push        (q_push),
    .q_data        (q_data),
    .q_full        (q_full)
  );

  // decouple byte production from bus delivery
  lcdw_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  // split bytes into bus transfers and hold each result until popped
  lcdw_back u_back (
    .clk             (clk),
    .rst             (rst),
    .four_bit_mode   (four_bit_mode),
    .head            (q_head),
    .q_empty         (q_empty),
    .q_pop           (q_pop),
    .empty           (empty),
    .pop             (pop),
    .register_select (register_select),
    .bus_value       (bus_value),
    .write_valid     (write_valid),
    .last            (last),
    .status          (status)
  );

endmodule

/* src/lcdw_fifo.sv */
`include "assert_macros.svh"

module lcdw_fifo
  import lcdw_pkg::*;
#(
  parameter int DEPTH = FIFO_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  lcdw_req_t push_data,
  output logic      full,
  input  logic      pop,
  output lcdw_req_t head,
  output logic      empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  lcdw_req_t          mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push;
  logic               do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `ASSERT_CLK(fifo_count_bound, clk, rst, count <= CNT_W'(DEPTH))
  `ASSERT_CLK(fifo_push_moves_count, clk, rst,
              (do_push && !do_pop) |=> (count == $past(count) + 1'b1))

endmodule

/* src/lcdw_front.sv */
`include "assert_macros.svh"

module lcdw_front
  import lcdw_pkg::*;
#(
  parameter int NUMBER_BITS = NUMBER_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [1:0]        cmd,
  input  logic [7:0]        byte_value,
  input  logic signed [31:0] number,
  input  logic              signed_mode,
  input  logic [3:0]        number_format,
  input  logic [2:0]        line,
  input  logic [5:0]        column,
  input  logic [2:0]        max_lines,
  input  logic [5:0]        max_columns,
  output logic              q_push,
  output lcdw_req_t         q_data,
  input  logic              q_full
);

  localparam int BIT_W = $clog2(NUMBER_BITS);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CONV = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0]             state;
  logic                   one_req;
  lcdw_req_t              one_data;
  logic                   sign_pend;
  logic                   neg;
  logic                   hex;
  logic [2:0]             nd;
  logic [2:0]             pos;
  logic [NUMBER_BITS-1:0] mag;
  logic [BCD_W-1:0]       bcd;
  logic [BIT_W-1:0]       bitcnt;

  logic                   accept;
  logic [NUMBER_BITS-1:0] raw;
  logic                   neg_in;
  logic [NUMBER_BITS-1:0] mag_in;
  logic [3:0]             fmt;
  logic                   hex_in;
  logic [2:0]             nd_in;
  logic [2:0]             ml;
  logic [5:0]             mc;
  logic                   loc_err;
  logic [7:0]             goto_addr;
  lcdw_req_t              one_in;
  logic [BCD_W-1:0]       dab;
  logic [NUM_MAX_BITS-1:0] mag_ext;
  logic                   sat;
  logic [3:0]             digit;
  logic [1:0]             num_status;
  logic                   do_push;

  assign full   = (state != S_IDLE);
  assign accept = push && (state == S_IDLE);

  // classify the incoming request
  always_comb begin
    raw    = number[NUMBER_BITS-1:0];
    neg_in = signed_mode && raw[NUMBER_BITS-1];
    mag_in = neg_in ? (~raw + 1'b1) : raw;
    fmt    = (number_format > 4'd8) ? 4'd8 : number_format;
    hex_in = (fmt >= 4'd5);
    nd_in  = hex_in ? 3'(fmt - 4'd4) : 3'(fmt + 4'd1);

    ml = (max_lines > 3'd4) ? 3'd4 : max_lines;
    mc = (max_columns > 6'd40) ? 6'd40 : max_columns;
    loc_err = (line == 3'd0) || (column == 6'd0) || (line > ml) || (column > mc);
    goto_addr = line_base(2'(line - 3'd1)) + {2'b00, column} - 8'd1;

    one_in.last = 1'b1;
    case (cmd)
      CMD_CHAR: begin
        one_in.rs     = 1'b1;
        one_in.data   = byte_value;
        one_in.valid  = 1'b1;
        one_in.status = ST_OK;
      end
      CMD_INSTR: begin
        one_in.rs     = 1'b0;
        one_in.data   = byte_value;
        one_in.valid  = 1'b1;
        one_in.status = ST_OK;
      end
      default: begin
        one_in.rs     = 1'b0;
        one_in.data   = loc_err ? 8'h00 : goto_addr;
        one_in.valid  = !loc_err;
        one_in.status = loc_err ? ST_LOC : ST_OK;
      end
    endcase
  end

  // binary to BCD: add three to every digit of five or more, then shift
  always_comb begin
    dab = bcd;
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (bcd[i*4 +: 4] >= 4'd5) dab[i*4 +: 4] = bcd[i*4 +: 4] + 4'd3;
    end
  end

  // saturation: any nonzero digit above the requested width
  always_comb begin
    mag_ext = NUM_MAX_BITS'(mag);
    sat = 1'b0;
    if (hex) begin
      for (int i = 0; i < NUM_MAX_BITS / 4; i++) begin
        if ((i >= int'(nd)) && (mag_ext[i*4 +: 4] != 4'd0)) sat = 1'b1;
      end
    end else begin
      for (int i = 0; i < BCD_DIGITS; i++) begin
        if ((i >= int'(nd)) && (bcd[i*4 +: 4] != 4'd0)) sat = 1'b1;
      end
    end
    num_status = sat ? ST_SAT : ST_OK;

    digit = hex ? mag_ext[{pos, 2'b00} +: 4] : bcd[{pos, 2'b00} +: 4];
    if (sat && (pos == nd - 3'd1)) digit = hex ? 4'hF : 4'd9;
  end

  always_comb begin
    if (one_req) begin
      q_data = one_data;
    end else begin
      q_data.rs     = 1'b1;
      q_data.valid  = 1'b1;
      q_data.status = num_status;
      if (sign_pend) begin
        q_data.data = neg ? CHAR_MINUS : CHAR_PLUS;
        q_data.last = 1'b0;
      end else begin
        q_data.data = digit_char(digit);
        q_data.last = (pos == 3'd0);
      end
    end
  end

  assign q_push  = (state == S_EMIT);
  assign do_push = q_push && !q_full;

  always_ff @(posedge clk) begin
    if (accept) begin
      one_data <= one_in;
      neg      <= neg_in;
      hex      <= hex_in;
      nd       <= nd_in;
      pos      <= nd_in - 3'd1;
      mag      <= mag_in;
      bcd      <= '0;
      bitcnt   <= BIT_W'(NUMBER_BITS - 1);
    end else if (state == S_CONV) begin
      bcd    <= {dab[BCD_W-2:0], mag[bitcnt]};
      bitcnt <= bitcnt - 1'b1;
    end else if (do_push && !one_req && !sign_pend) begin
      pos <= pos - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      one_req   <= 1'b0;
      sign_pend <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            one_req   <= (cmd != CMD_NUMBER);
            sign_pend <= (cmd == CMD_NUMBER) && signed_mode;
            if ((cmd == CMD_NUMBER) && (number_format < 4'd5)) state <= S_CONV;
            else                                                state <= S_EMIT;
          end
        end
        S_CONV: begin
          if (bitcnt == '0) state <= S_EMIT;
        end
        S_EMIT: begin
          if (do_push) begin
            if (one_req) begin
              state <= S_IDLE;
            end else if (sign_pend) begin
              sign_pend <= 1'b0;
            end else if (pos == 3'd0) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_CLK(front_digit_in_range, clk, rst,
              (state == S_EMIT && !one_req) |-> (pos < nd))
  `ASSERT_NEVER(front_push_while_idle, clk, rst, q_push && (state == S_IDLE))

endmodule

/* src/lcdw_back.sv */
`include "assert_macros.svh"

module lcdw_back
  import lcdw_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       four_bit_mode,
  input  lcdw_req_t  head,
  input  logic       q_empty,
  output logic       q_pop,
  output logic       empty,
  input  logic       pop,
  output logic       register_select,
  output logic [7:0] bus_value,
  output logic       write_valid,
  output logic       last,
  output logic [1:0] status
);

  logic       out_vld;
  logic       phase;
  logic       slot_free;
  logic       take;
  logic       split;
  logic [7:0] bus_next;

  assign slot_free = !out_vld || pop;
  assign take      = slot_free && !q_empty;
  // a real transfer in 4-bit mode leaves the queue only after its low nibble
  assign split     = head.valid && four_bit_mode;
  assign q_pop     = take && !(split && !phase);
  assign empty     = !out_vld;

  always_comb begin
    if (!head.valid)        bus_next = 8'h00;
    else if (!four_bit_mode) bus_next = head.data;
    else if (phase)         bus_next = {head.data[3:0], 4'h0};
    else                    bus_next = {head.data[7:4], 4'h0};
  end

  always_ff @(posedge clk) begin
    if (take) begin
      register_select <= head.rs;
      bus_value       <= bus_next;
      write_valid     <= head.valid;
      last            <= head.last && q_pop;
      status          <= head.status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
      phase   <= 1'b0;
    end else begin
      if (take)     out_vld <= 1'b1;
      else if (pop) out_vld <= 1'b0;
      if (take) phase <= split && !phase;
    end
  end

  `ASSERT_CLK(back_reject_is_last, clk, rst, (out_vld && !write_valid) |-> last)
  `ASSERT_CLK(back_phase_needs_nibbles, clk, rst, phase |-> (four_bit_mode && !q_empty))

endmodule

/* test/lcd_bus_transfer_check.sv */
module lcd_bus_transfer_check
  import lcdw_pkg::*;
#(
  parameter int NUMBER_BITS = NUMBER_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        full,
  input  logic [1:0]  cmd,
  input  logic [7:0]  byte_value,
  input  logic [31:0] number,
  input  logic        signed_mode,
  input  logic [3:0]  number_format,
  input  logic [2:0]  line,
  input  logic [5:0]  column,
  input  logic        empty,
  input  logic        pop,
  input  logic        register_select,
  input  logic [7:0]  bus_value,
  input  logic        write_valid,
  input  logic        last,
  input  logic [1:0]  status,
  input  logic        cfg_wr,
  input  logic [1:0]  cfg_addr,
  input  logic [5:0]  cfg_wdata,
  output int          fail_count,
  output int          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic       rs;
    logic [7:0] bus;
    logic       wv;
    logic       last;
    logic [1:0] st;
  } lcd_xfer_t;

  lcd_xfer_t  expected_xfers[$];
  lcd_xfer_t  staged_xfers[$];
  logic       nibble_mode;
  logic [2:0] line_limit;
  logic [5:0] column_limit;
  int         misses;

  function automatic logic [7:0] hex_glyph(input logic [3:0] d);
    return (d < 4'd10) ? 8'h30 + {4'd0, d} : 8'h37 + {4'd0, d};
  endfunction

  // Stage one byte as one or two bus transfers.
  function automatic void stage_byte(input logic rs, input logic [7:0] b);
    lcd_xfer_t x;
    x.rs = rs;
    x.wv = 1'b1;
    x.last = 1'b0;
    x.st = ST_OK;
    if (nibble_mode) begin
      x.bus = {b[7:4], 4'h0};
      staged_xfers.push_back(x);
      x.bus = {b[3:0], 4'h0};
      staged_xfers.push_back(x);
    end else begin
      x.bus = b;
      staged_xfers.push_back(x);
    end
  endfunction

  // Expand one accepted request into its bus transfers.
  function automatic void format_request();
    logic [1:0]  st;
    logic [63:0] mask, raw, mag, place, lead, rest, radix, d;
    logic [3:0]  fmt;
    logic        hexfmt;
    int          ndig;
    logic [2:0]  ml;
    logic [5:0]  mc;
    logic [7:0]  row_base;
    lcd_xfer_t   x;
    staged_xfers.delete();
    st = ST_OK;
    case (cmd)
      CMD_CHAR:  stage_byte(1'b1, byte_value);
      CMD_INSTR: stage_byte(1'b0, byte_value);
      CMD_NUMBER: begin
        mask = (NUMBER_BITS >= 64) ? '1 : ((64'd1 << NUMBER_BITS) - 64'd1);
        raw = {32'd0, number} & mask;
        mag = raw;
        if (signed_mode) begin
          if (raw[NUMBER_BITS-1]) begin
            mag = (~raw + 64'd1) & mask;
            if (mag == 0) mag = 64'd1 << (NUMBER_BITS - 1);
          end
          stage_byte(1'b1, raw[NUMBER_BITS-1] ? CHAR_MINUS : CHAR_PLUS);
        end
        fmt = (number_format > 4'd8) ? 4'd8 : number_format;
        hexfmt = (fmt >= 4'd5);
        ndig = hexfmt ? int'(fmt) - 4 : int'(fmt) + 1;
        radix = hexfmt ? 64'd16 : 64'd10;
        place = 64'd1;
        for (int i = 1; i < ndig; i++) place = place * radix;
        lead = mag / place;
        rest = mag % place;
        // saturate the leading digit when the value does not fit
        if (lead >= radix) begin
          lead = radix - 64'd1;
          st = ST_SAT;
        end
        stage_byte(1'b1, hex_glyph(lead[3:0]));
        while (place > 64'd1) begin
          place = place / radix;
          d = rest / place;
          stage_byte(1'b1, hex_glyph(d[3:0]));
          rest = rest % place;
        end
      end
      default: begin
        ml = (line_limit > 3'd4) ? 3'd4 : line_limit;
        mc = (column_limit > 6'd40) ? 6'd40 : column_limit;
        if (line == 3'd0 || column == 6'd0 || line > ml || column > mc) begin
          st = ST_LOC;
          x.rs = 1'b0;
          x.bus = 8'h00;
          x.wv = 1'b0;
          x.last = 1'b0;
          x.st = ST_OK;
          staged_xfers.push_back(x);
        end else begin
          case (line)
            3'd1:    row_base = 8'h80;
            3'd2:    row_base = 8'hC0;
            3'd3:    row_base = 8'h94;
            default: row_base = 8'hD4;
          endcase
          stage_byte(1'b0, row_base + {2'b00, column} - 8'd1);
        end
      end
    endcase
    foreach (staged_xfers[i]) begin
      x = staged_xfers[i];
      x.st = st;
      x.last = (i == staged_xfers.size() - 1);
      expected_xfers.push_back(x);
    end
  endfunction

  always @(posedge clk) begin : watch
    lcd_xfer_t exp_x;
    if (rst) begin
      nibble_mode = 1'b1;
      line_limit = 3'd4;
      column_limit = 6'd20;
      expected_xfers.delete();
      misses = 0;
    end else begin
      if (cfg_wr) begin
        case (cfg_addr)
          REG_FOUR_BIT:    nibble_mode = cfg_wdata[0];
          REG_MAX_LINES:   line_limit = cfg_wdata[2:0];
          REG_MAX_COLUMNS: column_limit = cfg_wdata[5:0];
          default: ;
        endcase
      end
      if (pop && !empty) begin
        if (expected_xfers.size() == 0) begin
          if (misses < 10)
            $display("unexpected transfer: rs=%0d bus=%02h wv=%0d last=%0d st=%0d",
                     register_select, bus_value, write_valid, last, status);
          misses++;
        end else begin
          exp_x = expected_xfers.pop_front();
          if (register_select !== exp_x.rs || bus_value !== exp_x.bus ||
              write_valid !== exp_x.wv || last !== exp_x.last || status !== exp_x.st) begin
            if (misses < 10)
              $display("transfer mismatch: expected rs=%0d bus=%02h wv=%0d last=%0d st=%0d, %s",
                       exp_x.rs, exp_x.bus, exp_x.wv, exp_x.last, exp_x.st,
                       $sformatf("got rs=%0d bus=%02h wv=%0d last=%0d st=%0d",
                                 register_select, bus_value, write_valid, last, status));
            misses++;
          end
        end
      end
      if (push && !full) format_request();
    end
    fail_count <= misses;
    outstanding <= expected_xfers.size();
  end

endmodule

/* test/char_lcd_format_and_bus_writer_unit_tb.sv */
module char_lcd_format_and_bus_writer_unit_tb;
  import lcdw_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int LONG_HOLD    = 300;
  localparam int SETTLE_CYCLES = 4;
  localparam int END_DRAIN    = 64;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               push = 1'b0;
  logic               full;
  logic [1:0]         cmd = CMD_CHAR;
  logic [7:0]         byte_value = 8'h00;
  logic signed [31:0] number = 32'sd0;
  logic               signed_mode = 1'b0;
  logic [3:0]         number_format = 4'd0;
  logic [2:0]         line = 3'd0;
  logic [5:0]         column = 6'd0;
  logic               empty;
  logic               pop = 1'b0;
  logic               register_select;
  logic [7:0]         bus_value;
  logic               write_valid;
  logic               last;
  logic [1:0]         status;
  logic               cfg_wr = 1'b0;
  logic [1:0]         cfg_addr = REG_FOUR_BIT;
  logic [5:0]         cfg_wdata = 6'd0;

  int fail_count;
  int outstanding;
  int cycles = 0;

  // Shared flags between the request and result processes.
  bit quiet_tail = 1'b0;   // no idling on either side once set
  bit long_hold  = 1'b0;   // ask the result side for one long hold-off

  char_lcd_format_and_bus_writer_unit DUT (
    .clk(clk), .rst(rst),
    .push(push), .full(full),
    .cmd(cmd), .byte_value(byte_value), .number(number), .signed_mode(signed_mode),
    .number_format(number_format), .line(line), .column(column),
    .empty(empty), .pop(pop),
    .register_select(register_select), .bus_value(bus_value),
    .write_valid(write_valid), .last(last), .status(status),
    .cfg_wr(cfg_wr), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  lcd_bus_transfer_check XFER_CHECK (
    .clk(clk), .rst(rst),
    .push(push), .full(full),
    .cmd(cmd), .byte_value(byte_value), .number(number), .signed_mode(signed_mode),
    .number_format(number_format), .line(line), .column(column),
    .empty(empty), .pop(pop),
    .register_select(register_select), .bus_value(bus_value),
    .write_valid(write_valid), .last(last), .status(status),
    .cfg_wr(cfg_wr), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .outstanding(outstanding)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog: end the run if the block stops making progress.
  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("[char_lcd_format_and_bus_writer_unit] ERROR");
    $finish;
  end

  // Result side: pop most cycles, idle in random bursts, and serve one long
  // hold-off on request so the byte queue backs up into full.
  initial begin : result_side
    do @(posedge clk); while (rst);
    forever begin
      if (long_hold) begin
        pop <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold = 1'b0;
      end else if (quiet_tail || $urandom_range(0, 7) != 0) begin
        pop <= 1'b1;
        @(posedge clk);
      end else begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
    end
  end

  // Offer one request and hold it until the block takes it. Leave push high
  // so a back-to-back request needs no second assignment in the same step.
  task automatic send_request(input logic [1:0] c, input logic [7:0] b,
                              input logic [31:0] n, input logic s,
                              input logic [3:0] f, input logic [2:0] ln,
                              input logic [5:0] col);
    push <= 1'b1;
    cmd <= c;
    byte_value <= b;
    number <= n;
    signed_mode <= s;
    number_format <= f;
    line <= ln;
    column <= col;
    do @(posedge clk); while (full);
  endtask

  // Drop push for a random burst now and then.
  task automatic sender_gap();
    if (!quiet_tail && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  // Write one register once every pending transfer has drained.
  task automatic write_reg(input logic [1:0] idx, input logic [5:0] val);
    push <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr <= 1'b0;
  endtask

  // Mostly well-formed requests: small numbers, values at digit boundaries,
  // in-range gotos; the rest is raw random content.
  task automatic send_random_request();
    int          kind;
    int          pick;
    int          p;
    bit          hexfmt;
    logic [1:0]  c;
    logic [31:0] n;
    logic [3:0]  f;
    logic [2:0]  ln;
    logic [5:0]  col;
    kind = $urandom_range(0, 9);
    c = (kind < 2) ? CMD_CHAR : (kind < 4) ? CMD_INSTR : (kind < 8) ? CMD_NUMBER : CMD_GOTO;
    f = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
    pick = $urandom_range(0, 3);
    case (pick)
      0: n = $urandom;
      1: n = $urandom_range(0, 20000);
      2: n = -$urandom_range(0, 20000);
      default: begin
        // land right at or just under a power of the radix
        hexfmt = 1'($urandom_range(0, 1));
        p = hexfmt ? $urandom_range(1, 4) : $urandom_range(1, 5);
        n = 1;
        repeat (p) n = n * (hexfmt ? 32'd16 : 32'd10);
        n = n - $urandom_range(0, 1);
        f = hexfmt ? 4'(p + 4) : 4'(p - 1);
      end
    endcase
    if ($urandom_range(0, 4) == 0) begin
      ln = 3'($urandom_range(0, 7));
      col = 6'($urandom_range(0, 63));
    end else begin
      ln = 3'($urandom_range(1, 4));
      col = 6'($urandom_range(1, 40));
    end
    send_request(c, 8'($urandom_range(0, 255)), n, 1'($urandom_range(0, 1)), f, ln, col);
  endtask

  task automatic run_phase(input logic four, input logic [5:0] lines,
                           input logic [5:0] cols, input int count, input bit hold);
    write_reg(REG_FOUR_BIT, {5'd0, four});
    write_reg(REG_MAX_LINES, lines);
    write_reg(REG_MAX_COLUMNS, cols);
    if (hold) long_hold = 1'b1;
    repeat (count) begin
      send_random_request();
      sender_gap();
    end
  endtask

  initial begin : stimulus
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed part under the reset settings, written explicitly.
    write_reg(REG_FOUR_BIT, 6'd1);
    write_reg(REG_MAX_LINES, 6'd4);
    write_reg(REG_MAX_COLUMNS, 6'd20);
    send_request(CMD_CHAR,   8'h00, 32'd0, 1'b0, 4'd0, 3'd0, 6'd0);      sender_gap();
    send_request(CMD_CHAR,   8'hFF, 32'd0, 1'b0, 4'd0, 3'd0, 6'd0);      sender_gap();
    send_request(CMD_INSTR,  8'hA5, 32'd0, 1'b0, 4'd0, 3'd0, 6'd0);      sender_gap();
    send_request(CMD_INSTR,  8'h5A, 32'd0, 1'b0, 4'd0, 3'd0, 6'd0);      sender_gap();
    // numbers: digit boundaries, saturation, signs, the most negative value
    send_request(CMD_NUMBER, 8'h00, 32'd0, 1'b0, 4'd0, 3'd0, 6'd0);      sender_gap();
    send_request(CMD_NUMBER, 8'h00, 32'd9, 1'b0, 4'd0, 3'd0, 6'd0);      sender_gap();
    send_request(CMD_NUMBER, 8'h00, 32'd10, 1'b0, 4'd0, 3'd0, 6'd0);     sender_gap();
    send_request(CMD_NUMBER, 8'h00, 32'd99999, 1'b0, 4'd4, 3'd0, 6'd0);  sender_gap();
    send_request(CMD_NUMBER, 8'h00, 32'd100000, 1'b0, 4'd4, 3'd0, 6'd0); sender_gap();
    send_request(CMD_NUMBER, 8'h00, 32'hFFFFFFFF, 1'b1, 4'd4, 3'd0, 6'd0); sender_gap();
    send_request(CMD_NUMBER, 8'h00, 32'h80000000, 1'b1, 4'd4, 3'd0, 6'd0); sender_gap();
    send_request(CMD_NUMBER, 8'h00, 32'd0, 1'b1, 4'd2, 3'd0, 6'd0);      sender_gap();
    send_request(CMD_NUMBER, 8'h00, 32'h7FFFFFFF, 1'b1, 4'd8, 3'd0, 6'd0); sender_gap();
    send_request(CMD_NUMBER, 8'h00, 32'h0000FFFF, 1'b0, 4'd8, 3'd0, 6'd0); sender_gap();
    send_request(CMD_NUMBER, 8'h00, 32'h00010000, 1'b0, 4'd8, 3'd0, 6'd0); sender_gap();
    send_request(CMD_NUMBER, 8'h00, 32'h00000ABC, 1'b0, 4'd7, 3'd0, 6'd0); sender_gap();
    // format codes above 8 behave as four hex digits
    send_request(CMD_NUMBER, 8'h00, 32'h00001234, 1'b0, 4'd15, 3'd0, 6'd0); sender_gap();
    send_request(CMD_NUMBER, 8'h00, 32'hFFFFFFFF, 1'b0, 4'd3, 3'd0, 6'd0); sender_gap();
    // gotos: corners of the window and each way to fall outside it
    send_request(CMD_GOTO,   8'h00, 32'd0, 1'b0, 4'd0, 3'd1, 6'd1);      sender_gap();
    send_request(CMD_GOTO,   8'h00, 32'd0, 1'b0, 4'd0, 3'd4, 6'd20);     sender_gap();
    send_request(CMD_GOTO,   8'h00, 32'd0, 1'b0, 4'd0, 3'd0, 6'd1);      sender_gap();
    send_request(CMD_GOTO,   8'h00, 32'd0, 1'b0, 4'd0, 3'd1, 6'd0);      sender_gap();
    send_request(CMD_GOTO,   8'h00, 32'd0, 1'b0, 4'd0, 3'd5, 6'd1);      sender_gap();
    send_request(CMD_GOTO,   8'h00, 32'd0, 1'b0, 4'd0, 3'd1, 6'd21);     sender_gap();
    send_request(CMD_GOTO,   8'h00, 32'd0, 1'b0, 4'd0, 3'd7, 6'd63);     sender_gap();

    // Random phases across settings, out-of-range register values included.
    run_phase(1'b0, 6'd4, 6'd40, 33, 1'b1);
    run_phase(1'b1, 6'd1, 6'd1, 33, 1'b0);
    run_phase(1'b0, 6'd7, 6'd63, 33, 1'b0);
    run_phase(1'b1, 6'd0, 6'd0, 33, 1'b0);
    run_phase(1'b0, 6'd2, 6'd16, 33, 1'b0);
    quiet_tail = 1'b1;
    run_phase(1'b1, 6'd4, 6'd40, 40, 1'b0);

    // Drain every pending transfer, then give stragglers time to show.
    push <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (END_DRAIN) @(posedge clk);
    if (fail_count == 0) begin
      $display("[char_lcd_format_and_bus_writer_unit] OK");
    end else begin
      $display("[char_lcd_format_and_bus_writer_unit] ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+src
src/lcdw_pkg.sv
src/lcdw_fifo.sv
src/lcdw_front.sv
src/lcdw_back.sv
src/char_lcd_format_and_bus_writer_unit.sv
test/lcd_bus_transfer_check.sv
test/char_lcd_format_and_bus_writer_unit_tb.sv
